// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the track_state_waypoint_selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tsws_pkg.sv =====
package tsws_pkg;

    localparam int COORD_BITS = 24;
    localparam int THR_BITS   = 23;
    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1280);

    // Coordinate differences, shared multiplier operands and accumulator.
    localparam int DB  = COORD_BITS + 1;
    localparam int MB  = (COORD_BITS + 3 > THR_BITS + 1) ? COORD_BITS + 3 : THR_BITS + 1;
    localparam int LOB = MB - 1;
    localparam int DPB = 2 * DB + 1;
    localparam int PB  = 2 * MB;
    localparam int AB  = 3 * MB - 1;
    localparam int QB  = COORD_BITS + 3;
    localparam int QCB = $clog2(QB);
    localparam int SB  = 5;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));

    localparam logic [1:0] TS_ON_TRACK   = 2'd0;
    localparam logic [1:0] TS_GOAL_BEHIND = 2'd1;
    localparam logic [1:0] TS_PREV_AHEAD = 2'd2;
    localparam logic [1:0] TS_OFF_TRACK  = 2'd3;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic en;
        logic clr;
        logic sh;
    } t_mac_op;

endpackage

// ===== hw/rtl/tsws_if.sv =====
interface tsws_in_if import tsws_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord pos_x;
    t_coord pos_y;
    t_coord prev_wp_x;
    t_coord prev_wp_y;
    t_coord goal_x;
    t_coord goal_y;
    t_coord next_wp_x;
    t_coord next_wp_y;
    logic   set_changed;

    modport source (output valid, pos_x, pos_y, prev_wp_x, prev_wp_y, goal_x, goal_y,
                    next_wp_x, next_wp_y, set_changed, input ready);
    modport sink   (input valid, pos_x, pos_y, prev_wp_x, prev_wp_y, goal_x, goal_y,
                    next_wp_x, next_wp_y, set_changed, output ready);
endinterface

interface tsws_out_if import tsws_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] track_state;
    t_coord     out_target_x;
    t_coord     out_target_y;
    t_coord     out_prev_x;
    t_coord     out_prev_y;
    t_coord     out_next_x;
    t_coord     out_next_y;
    logic       reselected;

    modport source (output valid, track_state, out_target_x, out_target_y, out_prev_x,
                    out_prev_y, out_next_x, out_next_y, reselected, input ready);
    modport sink   (input valid, track_state, out_target_x, out_target_y, out_prev_x,
                    out_prev_y, out_next_x, out_next_y, reselected, output ready);
endinterface

// ===== hw/rtl/track_state_waypoint_selector.sv =====
// Each item runs two serial divisions that each give a 27-bit quotient; both are
// skipped when the previous and target waypoints coincide. A new item is taken
// only while idle, once the last one is through; it is taken while a result waits.
// Reset (synchronous, active low): stored state on track, held waypoints zero,
// threshold 1280.
`include "assert_macros.svh"

module track_state_waypoint_selector import tsws_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_data,
    tsws_in_if.sink             i_in,
    tsws_out_if.source          o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    localparam logic [SB-1:0] ST_DD     = SB'(3);
    localparam logic [SB-1:0] ST_DP     = SB'(5);
    localparam logic [SB-1:0] ST_DT     = SB'(7);
    localparam logic [SB-1:0] ST_P2     = SB'(9);
    localparam logic [SB-1:0] ST_BRANCH = SB'(10);
    localparam logic [SB-1:0] ST_X_LO   = SB'(11);
    localparam logic [SB-1:0] ST_X_HI   = SB'(12);
    localparam logic [SB-1:0] ST_X_DIV  = SB'(14);
    localparam logic [SB-1:0] ST_Y_LO   = SB'(15);
    localparam logic [SB-1:0] ST_Y_HI   = SB'(16);
    localparam logic [SB-1:0] ST_Y_DIV  = SB'(18);
    localparam logic [SB-1:0] ST_E_X    = SB'(19);
    localparam logic [SB-1:0] ST_E_Y    = SB'(20);
    localparam logic [SB-1:0] ST_CLASS  = SB'(22);

    t_state              r_state;
    logic [SB-1:0]       r_step;
    logic                r_axis;
    logic [THR_BITS-1:0] r_thr;
    t_coord              r_pos_x, r_pos_y, r_prev_x, r_prev_y;
    t_coord              r_goal_x, r_goal_y, r_next_x, r_next_y;
    logic                r_chg;
    logic [AB-1:0]       r_dd;
    logic [DPB-1:0]      r_dp;
    logic                r_dt_neg;
    logic [AB-1:0]       r_p2;
    logic [AB-1:0]       r_thr2;
    t_coord              r_cx, r_cy;
    logic [1:0]          r_cls;
    logic [1:0]          r_last;
    t_coord              r_tgt_x, r_tgt_y, r_hprev_x, r_hprev_y, r_hnext_x, r_hnext_y;
    logic                r_o_valid;
    logic [1:0]          r_o_state;
    logic                r_o_resel;

    logic signed [DB-1:0] w_dx, w_dy, w_px, w_py, w_tx, w_ty, w_ex, w_ey;
    logic signed [MB-1:0] w_a, w_b, w_lo, w_hi;
    t_mac_op              w_op;
    logic signed [AB-1:0] w_acc;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [QB-1:0]        w_q;
    logic                 w_q_neg;
    logic signed [QB+1:0] w_sum;
    t_coord               w_sat;
    t_coord               w_base;
    logic [1:0]           w_cls;
    logic                 w_resel;
    logic                 w_out_free;

    assign w_dx = DB'(r_goal_x) - DB'(r_prev_x);
    assign w_dy = DB'(r_goal_y) - DB'(r_prev_y);
    assign w_px = DB'(r_pos_x) - DB'(r_prev_x);
    assign w_py = DB'(r_pos_y) - DB'(r_prev_y);
    assign w_tx = DB'(r_goal_x) - DB'(r_pos_x);
    assign w_ty = DB'(r_goal_y) - DB'(r_pos_y);
    assign w_ex = DB'(r_pos_x) - DB'(r_cx);
    assign w_ey = DB'(r_pos_y) - DB'(r_cy);
    assign w_lo = $signed({1'b0, r_dp[LOB-1:0]});
    assign w_hi = MB'($signed(r_dp[DPB-1:LOB]));

    always_comb begin
        w_op = '0;
        w_a  = '0;
        w_b  = '0;
        if (r_state == S_MUL) begin
            case (r_step)
                SB'(0): begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = MB'(w_dx); w_b = MB'(w_dx);
                end
                SB'(1): begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b0}; w_a = MB'(w_dy); w_b = MB'(w_dy);
                end
                SB'(2): begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = MB'(w_dx); w_b = MB'(w_px);
                end
                SB'(3): begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b0}; w_a = MB'(w_dy); w_b = MB'(w_py);
                end
                SB'(4): begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = MB'(w_dx); w_b = MB'(w_tx);
                end
                SB'(5): begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b0}; w_a = MB'(w_dy); w_b = MB'(w_ty);
                end
                SB'(6): begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = MB'(w_px); w_b = MB'(w_px);
                end
                SB'(7): begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b0}; w_a = MB'(w_py); w_b = MB'(w_py);
                end
                SB'(8): begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0};
                    w_a  = $signed(MB'(r_thr));
                    w_b  = $signed(MB'(r_thr));
                end
                ST_X_LO: begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = w_lo; w_b = MB'(w_dx);
                end
                ST_X_HI: begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b1}; w_a = w_hi; w_b = MB'(w_dx);
                end
                ST_Y_LO: begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = w_lo; w_b = MB'(w_dy);
                end
                ST_Y_HI: begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b1}; w_a = w_hi; w_b = MB'(w_dy);
                end
                ST_E_X: begin
                    w_op = '{en: 1'b1, clr: 1'b1, sh: 1'b0}; w_a = MB'(w_ex); w_b = MB'(w_ex);
                end
                ST_E_Y: begin
                    w_op = '{en: 1'b1, clr: 1'b0, sh: 1'b0}; w_a = MB'(w_ey); w_b = MB'(w_ey);
                end
                default: begin
                    w_op = '0;
                end
            endcase
        end
    end

    tsws_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_acc   (w_acc)
    );

    assign w_div_start = (r_state == S_MUL) && ((r_step == ST_X_DIV) || (r_step == ST_Y_DIV));

    tsws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_acc),
        .i_dd    (r_dd),
        .o_done  (w_div_done),
        .o_q     (w_q),
        .o_neg   (w_q_neg)
    );

    always_comb begin
        w_base = r_axis ? r_prev_y : r_prev_x;
        w_sum  = (QB+2)'(w_base) + (w_q_neg ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q}));
        if (w_sum > $signed((QB+2)'(COORD_MAX))) begin
            w_sat = COORD_BITS'(COORD_MAX);
        end else if (w_sum < $signed((QB+2)'(COORD_MIN))) begin
            w_sat = COORD_BITS'(COORD_MIN);
        end else begin
            w_sat = COORD_BITS'(w_sum);
        end
    end

    always_comb begin
        if (r_dt_neg) begin
            w_cls = TS_GOAL_BEHIND;
        end else if (r_dp[DPB-1] && (r_p2 > r_thr2)) begin
            w_cls = TS_PREV_AHEAD;
        end else if ($unsigned(w_acc) > r_thr2) begin
            w_cls = TS_OFF_TRACK;
        end else begin
            w_cls = TS_ON_TRACK;
        end
    end

    assign w_out_free = !r_o_valid || o_out.ready;
    assign w_resel    = r_chg || (r_cls != r_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_axis    <= 1'b0;
            r_thr     <= THR_RESET;
            r_last    <= TS_ON_TRACK;
            r_tgt_x   <= '0;
            r_tgt_y   <= '0;
            r_hprev_x <= '0;
            r_hprev_y <= '0;
            r_hnext_x <= '0;
            r_hnext_y <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (r_o_valid && o_out.ready && !(r_state == S_FIN && w_out_free)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_MUL;
                        r_step  <= '0;
                    end
                end
                S_MUL: begin
                    if (r_step == ST_BRANCH && r_dd == '0) begin
                        r_step <= ST_E_X;
                    end else begin
                        r_step <= r_step + 1'b1;
                        if (r_step == ST_X_DIV) begin
                            r_state <= S_DIV;
                            r_axis  <= 1'b0;
                        end else if (r_step == ST_Y_DIV) begin
                            r_state <= S_DIV;
                            r_axis  <= 1'b1;
                        end else if (r_step == ST_CLASS) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                        r_step  <= r_axis ? ST_E_X : ST_Y_LO;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state   <= S_IDLE;
                        r_last    <= r_cls;
                        r_o_valid <= 1'b1;
                        if (w_resel) begin
                            case (r_cls)
                                TS_GOAL_BEHIND: begin
                                    r_tgt_x   <= r_goal_x; r_tgt_y   <= r_goal_y;
                                    r_hprev_x <= r_pos_x;  r_hprev_y <= r_pos_y;
                                    r_hnext_x <= r_next_x; r_hnext_y <= r_next_y;
                                end
                                TS_PREV_AHEAD: begin
                                    r_tgt_x   <= r_prev_x; r_tgt_y   <= r_prev_y;
                                    r_hprev_x <= r_pos_x;  r_hprev_y <= r_pos_y;
                                    r_hnext_x <= r_goal_x; r_hnext_y <= r_goal_y;
                                end
                                TS_OFF_TRACK: begin
                                    r_tgt_x   <= r_cx;     r_tgt_y   <= r_cy;
                                    r_hprev_x <= r_pos_x;  r_hprev_y <= r_pos_y;
                                    r_hnext_x <= r_goal_x; r_hnext_y <= r_goal_y;
                                end
                                default: begin
                                    r_tgt_x   <= r_goal_x; r_tgt_y   <= r_goal_y;
                                    r_hprev_x <= r_prev_x; r_hprev_y <= r_prev_y;
                                    r_hnext_x <= r_next_x; r_hnext_y <= r_next_y;
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_pos_x  <= i_in.pos_x;
            r_pos_y  <= i_in.pos_y;
            r_prev_x <= i_in.prev_wp_x;
            r_prev_y <= i_in.prev_wp_y;
            r_goal_x <= i_in.goal_x;
            r_goal_y <= i_in.goal_y;
            r_next_x <= i_in.next_wp_x;
            r_next_y <= i_in.next_wp_y;
            r_chg    <= i_in.set_changed;
        end
        if (r_state == S_MUL) begin
            case (r_step)
                ST_DD: r_dd <= $unsigned(w_acc);
                ST_DP: r_dp <= w_acc[DPB-1:0];
                ST_DT: r_dt_neg <= w_acc[AB-1];
                ST_P2: r_p2 <= $unsigned(w_acc);
                ST_BRANCH: begin
                    r_thr2 <= $unsigned(w_acc);
                    r_cx   <= r_prev_x;
                    r_cy   <= r_prev_y;
                end
                ST_CLASS: r_cls <= w_cls;
                default: begin
                end
            endcase
        end
        if (r_state == S_DIV && w_div_done) begin
            if (r_axis) begin
                r_cy <= w_sat;
            end else begin
                r_cx <= w_sat;
            end
        end
        if (r_state == S_FIN && w_out_free) begin
            r_o_state <= r_cls;
            r_o_resel <= w_resel;
        end
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.track_state  = r_o_state;
    assign o_out.out_target_x = r_tgt_x;
    assign o_out.out_target_y = r_tgt_y;
    assign o_out.out_prev_x   = r_hprev_x;
    assign o_out.out_prev_y   = r_hprev_y;
    assign o_out.out_next_x   = r_hnext_x;
    assign o_out.out_next_y   = r_hnext_y;
    assign o_out.reselected   = r_o_resel;

    `ASSERT_CLK(a_transfer_starts, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> (r_state == S_MUL), "Input transfer did not start the sequencer.")
    `ASSERT_CLK(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_dd != '0), "Division entered with a degenerate line.")
    `ASSERT_CLK(a_out_from_fin, i_clk, i_rst_n, $rose(o_out.valid) |-> ($past(r_state) == S_FIN), "Result raised outside the final step.")

endmodule

// ===== hw/rtl/tsws_mac.sv =====
module tsws_mac import tsws_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mac_op              i_op,
    input  logic signed [MB-1:0] i_a,
    input  logic signed [MB-1:0] i_b,
    output logic signed [AB-1:0] o_acc
);

    t_mac_op              r_op;
    logic signed [PB-1:0] r_prod;
    logic signed [AB-1:0] r_acc;
    logic signed [AB-1:0] n_acc;
    logic signed [AB-1:0] w_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= '0;
        end else begin
            r_op <= i_op;
        end
        r_prod <= i_a * i_b;
        r_acc  <= n_acc;
    end

    always_comb begin
        w_ext = AB'(r_prod);
        if (r_op.sh) begin
            w_ext = w_ext <<< LOB;
        end
        n_acc = r_acc;
        if (r_op.en) begin
            n_acc = (r_op.clr ? '0 : r_acc) + w_ext;
        end
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/tsws_div.sv =====
module tsws_div import tsws_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AB-1:0] i_num,
    input  logic [AB-1:0]        i_dd,
    output logic                 o_done,
    output logic [QB-1:0]        o_q,
    output logic                 o_neg
);

    logic           r_busy;
    logic           r_done;
    logic [QCB-1:0] r_cnt;
    logic [AB-1:0]  r_rem;
    logic [AB-1:0]  r_den;
    logic [QB-1:0]  r_q;
    logic           r_neg;
    logic [AB-1:0]  w_mag;
    logic           w_ge;

    assign w_mag = i_num[AB-1] ? AB'(-i_num) : AB'(i_num);
    assign w_ge  = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= QCB'(QB - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            // Rounded quotient: floor((2|num| + dd) / (2 dd)).
            r_rem <= (w_mag << 1) + i_dd;
            r_den <= i_dd << QB;
            r_q   <= '0;
            r_neg <= i_num[AB-1];
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_den;
            end
            r_den <= r_den >> 1;
            r_q   <= {r_q[QB-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_neg  = r_neg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import tsws_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_coord pos_x;
        t_coord pos_y;
        t_coord prev_x;
        t_coord prev_y;
        t_coord goal_x;
        t_coord goal_y;
        t_coord nxt_x;
        t_coord nxt_y;
        logic   changed;
    } t_fix;

    typedef struct {
        logic [1:0] state;
        t_coord     wp[6];
        logic       resel;
    } t_guidance;

    class track_scoreboard;
        logic [THR_BITS-1:0] threshold;
        logic [1:0]          stored_state;
        t_coord              held[6];
        t_guidance           pending[$];
        int                  errors;

        function new();
            threshold    = THR_RESET;
            stored_state = TS_ON_TRACK;
            foreach (held[i]) held[i] = '0;
            errors = 0;
        endfunction

        function t_wide magnitude(t_wide v);
            return (v < 0) ? -v : v;
        endfunction

        function t_wide project(t_wide base, t_wide d, t_wide dp, t_wide dd);
            t_wide num;
            t_wide q;
            t_wide c;
            logic  neg;
            num = magnitude(dp) * magnitude(d);
            neg = ((dp < 0) != (d < 0)) && (num != 0);
            q   = (2 * num + dd) / (2 * dd);
            c   = neg ? base - q : base + q;
            if (c > COORD_MAX) c = COORD_MAX;
            if (c < COORD_MIN) c = COORD_MIN;
            return c;
        endfunction

        function void note_fix(t_fix f);
            t_wide     vx, vy, px0, py0, gx, gy, dx, dy, px, py, tx, ty;
            t_wide     dd, dp, dt, thr2, cx, cy, ex, ey;
            logic [1:0] cls;
            t_guidance g;
            vx = t_wide'(f.pos_x);  vy = t_wide'(f.pos_y);
            px0 = t_wide'(f.prev_x); py0 = t_wide'(f.prev_y);
            gx = t_wide'(f.goal_x); gy = t_wide'(f.goal_y);
            dx = gx - px0; dy = gy - py0;
            px = vx - px0; py = vy - py0;
            tx = gx - vx;  ty = gy - vy;
            dd = dx * dx + dy * dy;
            dp = dx * px + dy * py;
            dt = dx * tx + dy * ty;
            thr2 = t_wide'({1'b0, threshold}) * t_wide'({1'b0, threshold});
            cx = px0; cy = py0;
            if (dd != 0) begin
                cx = project(px0, dx, dp, dd);
                cy = project(py0, dy, dp, dd);
            end
            ex = vx - cx; ey = vy - cy;
            if (dt < 0) begin
                cls = TS_GOAL_BEHIND;
            end else if (dp < 0 && px * px + py * py > thr2) begin
                cls = TS_PREV_AHEAD;
            end else if (ex * ex + ey * ey > thr2) begin
                cls = TS_OFF_TRACK;
            end else begin
                cls = TS_ON_TRACK;
            end
            g.resel = f.changed || (cls != stored_state);
            stored_state = cls;
            if (g.resel) begin
                case (cls)
                    TS_GOAL_BEHIND: held = '{f.goal_x, f.goal_y, f.pos_x, f.pos_y,
                                             f.nxt_x, f.nxt_y};
                    TS_PREV_AHEAD:  held = '{f.prev_x, f.prev_y, f.pos_x, f.pos_y,
                                             f.goal_x, f.goal_y};
                    TS_OFF_TRACK:   held = '{t_coord'(cx), t_coord'(cy), f.pos_x, f.pos_y,
                                             f.goal_x, f.goal_y};
                    default:        held = '{f.goal_x, f.goal_y, f.prev_x, f.prev_y,
                                             f.nxt_x, f.nxt_y};
                endcase
            end
            g.state = cls;
            g.wp    = held;
            pending.push_back(g);
        endfunction

        function void check_guidance(t_guidance r);
            t_guidance e;
            string names[6];
            names = '{"out_target_x", "out_target_y", "out_prev_x", "out_prev_y",
                      "out_next_x", "out_next_y"};
            if (pending.size() == 0) begin
                $error("result transfer with no result outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r.state !== e.state) begin
                $error("track_state expected %0d actual %0d", e.state, r.state);
                errors++;
            end
            for (int i = 0; i < 6; i++) begin
                if (r.wp[i] !== e.wp[i]) begin
                    $error("%s expected %0d actual %0d", names[i], e.wp[i], r.wp[i]);
                    errors++;
                end
            end
            if (r.resel !== e.resel) begin
                $error("reselected expected %0d actual %0d", e.resel, r.resel);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [THR_BITS-1:0] i_cfg_data = '0;
    tsws_in_if           in_if();
    tsws_out_if          out_if();
    track_scoreboard     sb = new();
    bit                  hold_request = 1'b0;
    bit                  steady = 1'b0;

    track_state_waypoint_selector DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_if),
        .o_out     (out_if)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #(40_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        t_guidance r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            r.state = out_if.track_state;
            r.wp    = '{out_if.out_target_x, out_if.out_target_y, out_if.out_prev_x,
                        out_if.out_prev_y, out_if.out_next_x, out_if.out_next_y};
            r.resel = out_if.reselected;
            sb.check_guidance(r);
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_if.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (pick_gap() == 0) begin
                out_if.ready = 1'b1;
            end else begin
                out_if.ready = 1'b0;
            end
        end
    end

    function automatic t_coord rand_coord();
        return t_coord'($urandom());
    endfunction

    function automatic t_coord near(t_coord base, int span);
        return t_coord'(int'(base) + $signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_fix random_fix();
        t_fix f;
        int   span;
        int   mode;
        mode = $urandom_range(0, 9);
        span = 1 << $urandom_range(0, 20);
        f.prev_x = rand_coord();
        f.prev_y = rand_coord();
        f.nxt_x  = rand_coord();
        f.nxt_y  = rand_coord();
        f.changed = ($urandom_range(0, 3) == 0);
        if (mode == 0) begin
            f.pos_x = rand_coord();  f.pos_y = rand_coord();
            f.goal_x = rand_coord(); f.goal_y = rand_coord();
        end else if (mode == 1) begin
            f.goal_x = f.prev_x; f.goal_y = f.prev_y;
            f.pos_x = near(f.prev_x, span); f.pos_y = near(f.prev_y, span);
        end else if (mode == 2) begin
            f.pos_x  = $urandom_range(0, 1) ? t_coord'(COORD_MAX) : t_coord'(COORD_MIN);
            f.pos_y  = $urandom_range(0, 1) ? t_coord'(COORD_MAX) : t_coord'(COORD_MIN);
            f.goal_x = $urandom_range(0, 1) ? t_coord'(COORD_MAX) : t_coord'(COORD_MIN);
            f.goal_y = $urandom_range(0, 1) ? t_coord'(COORD_MAX) : rand_coord();
            f.prev_x = $urandom_range(0, 1) ? t_coord'(COORD_MIN) : f.prev_x;
        end else begin
            f.prev_x = near(t_coord'(0), 1 << 22);
            f.prev_y = near(t_coord'(0), 1 << 22);
            f.goal_x = near(f.prev_x, span);
            f.goal_y = near(f.prev_y, span);
            f.pos_x  = near(f.prev_x, span + span / 2);
            f.pos_y  = near(f.prev_y, span + span / 2);
        end
        return f;
    endfunction

    function automatic t_fix make_fix(int px, int py, int vx, int vy, int gx, int gy,
                                      int nx, int ny, logic ch);
        t_fix f;
        f.pos_x = t_coord'(px);  f.pos_y = t_coord'(py);
        f.prev_x = t_coord'(vx); f.prev_y = t_coord'(vy);
        f.goal_x = t_coord'(gx); f.goal_y = t_coord'(gy);
        f.nxt_x = t_coord'(nx);  f.nxt_y = t_coord'(ny);
        f.changed = ch;
        return f;
    endfunction

    task automatic send_fix(t_fix f);
        int gap;
        in_if.pos_x = f.pos_x;       in_if.pos_y = f.pos_y;
        in_if.prev_wp_x = f.prev_x;  in_if.prev_wp_y = f.prev_y;
        in_if.goal_x = f.goal_x;     in_if.goal_y = f.goal_y;
        in_if.next_wp_x = f.nxt_x;   in_if.next_wp_y = f.nxt_y;
        in_if.set_changed = f.changed;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_fix(f);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        in_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_BITS-1:0] v);
        drain();
        i_cfg_we = 1'b1;
        i_cfg_data = v;
        sb.threshold = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    initial begin
        logic [THR_BITS-1:0] settings[8];
        int mx;
        int mn;
        mx = int'(COORD_MAX);
        mn = int'(COORD_MIN);
        in_if.valid = 1'b0;
        in_if.pos_x = '0;     in_if.pos_y = '0;
        in_if.prev_wp_x = '0; in_if.prev_wp_y = '0;
        in_if.goal_x = '0;    in_if.goal_y = '0;
        in_if.next_wp_x = '0; in_if.next_wp_y = '0;
        in_if.set_changed = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_fix(make_fix(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_fix(make_fix(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_fix(make_fix(5000, 100, 0, 0, 10000, 0, 20000, 5, 1'b0));
        send_fix(make_fix(12000, 0, 0, 0, 10000, 0, 20000, 5, 1'b0));
        send_fix(make_fix(-5000, 0, 0, 0, 10000, 0, 20000, 5, 1'b0));
        send_fix(make_fix(5000, 3000, 0, 0, 10000, 0, 20000, 5, 1'b0));
        send_fix(make_fix(5000, 3000, 0, 0, 10000, 0, 20000, 5, 1'b0));
        send_fix(make_fix(1, 0, 0, 0, 2, 2, 7, 7, 1'b1));
        send_fix(make_fix(-1, 0, 0, 0, 2, 2, 7, 7, 1'b1));
        send_fix(make_fix(9000, 9000, 100, 100, 100, 100, 3, 3, 1'b0));
        send_fix(make_fix(mx, mx, mx, mx, mx, mx, mx, mx, 1'b1));
        send_fix(make_fix(mn, mn, mn, mn, mn, mn, mn, mn, 1'b1));
        send_fix(make_fix(mx, mn, mn, mx, mx, mn, mn, mx, 1'b0));
        send_fix(make_fix(mn, mx, mn, mn, mx, mx, mx, mn, 1'b0));
        send_fix(make_fix(mx, mn, mn, mn, mx, mx, mn, mn, 1'b1));

        settings = '{THR_RESET, 23'd0, 23'h7FFFFF, 23'd1, 23'd256, 23'd40000, 23'd3000, 23'd0};
        settings[7] = THR_BITS'($urandom_range(1, 200000));
        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) write_threshold(settings[ph]);
            steady = (ph == 3);
            if (ph == 2) hold_request = 1'b1;
            for (int n = 0; n < 160; n++) send_fix(random_fix());
        end
        drain();

        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
